[rtl/core/perlin_noise_2d_assert.svh]
// Assertion macros for the checker of the 2D gradient noise block.
`ifndef PERLIN_NOISE_2D_ASSERT_SVH
`define PERLIN_NOISE_2D_ASSERT_SVH

// same-cycle implication
`define PN2D_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define PN2D_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/pn2d_pkg.sv]
// Shared types and constants of the 2D gradient noise block.
package pn2d_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int TABLE_SIZE    = 256;
   localparam int IDX_W         = $clog2(TABLE_SIZE);
   localparam int VAL_W         = 8;
   localparam int COORD_W       = 24;
   localparam int OUT_W         = 19;
   localparam int OUT_FRAC      = 16;
   localparam int OUT_MIN       = -65536;
   localparam int OUT_MAX       = 131072;
   localparam int REQ_DATA_W    = 2 * COORD_W + IDX_W + VAL_W;
   localparam int REQ_USER_W    = 1;
   localparam int RSP_DATA_W    = ((OUT_W + 7) / 8) * 8;
   localparam int FIFO_DEPTH    = 16;
   localparam int PIPE_LAT      = 8;

   typedef enum logic {
      MODE_LOAD = 1'b0,
      MODE_EVAL = 1'b1
   } mode_type;

   typedef logic [IDX_W-1:0] idx_type;
   typedef logic [VAL_W-1:0] val_type;

   typedef struct packed {
      logic    en;
      idx_type addr;
      val_type data;
   } wr_type;

   typedef struct packed {
      val_type aa;
      val_type ab;
      val_type ba;
      val_type bb;
   } hash_type;

endpackage

[rtl/core/pn2d_perm_ram.sv]
// One copy of the permutation table: one write port, two registered read ports.
module pn2d_perm_ram (
   input  logic              clock,
   input  pn2d_pkg::wr_type  wr,
   input  logic              rd_en,
   input  pn2d_pkg::idx_type rd_addr_a,
   input  pn2d_pkg::idx_type rd_addr_b,
   output pn2d_pkg::val_type rd_data_a,
   output pn2d_pkg::val_type rd_data_b
);
   import pn2d_pkg::*;

   val_type mem [TABLE_SIZE];
   val_type rd_a_ff;
   val_type rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_a_ff <= mem[rd_addr_a];
         rd_b_ff <= mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

[rtl/core/pn2d_hash.sv]
// Two-level corner hash over three copies of the permutation table.
module pn2d_hash (
   input  logic               clock,
   input  pn2d_pkg::wr_type   wr,
   input  logic               rd_en,
   input  pn2d_pkg::idx_type  cx,
   input  pn2d_pkg::idx_type  cy,
   output pn2d_pkg::hash_type hash
);
   import pn2d_pkg::*;

   idx_type cy_ff;
   idx_type cx_next;
   val_type hx0;
   val_type hx1;
   idx_type addr_a0;
   idx_type addr_a1;
   idx_type addr_b0;
   idx_type addr_b1;
   val_type h_aa;
   val_type h_ab;
   val_type h_ba;
   val_type h_bb;

   assign cx_next = cx + IDX_W'(1);

   pn2d_perm_ram u_ram_x (
      .clock     (clock),
      .wr        (wr),
      .rd_en     (rd_en),
      .rd_addr_a (cx),
      .rd_addr_b (cx_next),
      .rd_data_a (hx0),
      .rd_data_b (hx1)
   );

   always_ff @(posedge clock) begin
      cy_ff <= cy;
   end

   assign addr_a0 = idx_type'(hx0) + cy_ff;
   assign addr_a1 = addr_a0 + IDX_W'(1);
   assign addr_b0 = idx_type'(hx1) + cy_ff;
   assign addr_b1 = addr_b0 + IDX_W'(1);

   pn2d_perm_ram u_ram_a (
      .clock     (clock),
      .wr        (wr),
      .rd_en     (1'b1),
      .rd_addr_a (addr_a0),
      .rd_addr_b (addr_a1),
      .rd_data_a (h_aa),
      .rd_data_b (h_ab)
   );

   pn2d_perm_ram u_ram_b (
      .clock     (clock),
      .wr        (wr),
      .rd_en     (1'b1),
      .rd_addr_a (addr_b0),
      .rd_addr_b (addr_b1),
      .rd_data_a (h_ba),
      .rd_data_b (h_bb)
   );

   assign hash = '{aa: h_aa, ab: h_ab, ba: h_ba, bb: h_bb};

endmodule

[rtl/core/pn2d_fade.sv]
// Quintic fade 6t^5-15t^4+10t^3 by Horner's rule, four multiply stages.
module pn2d_fade #(
   parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic [FRAC_BITS-1:0] t_in,
   output logic [FRAC_BITS:0]   fade
);
   import pn2d_pkg::*;

   localparam int AW = FRAC_BITS + 5;
   localparam int BW = FRAC_BITS + 4;
   localparam int CW = FRAC_BITS + 2;

   logic [FRAC_BITS-1:0]          t0_ff;
   logic [FRAC_BITS-1:0]          t1_ff;
   logic [FRAC_BITS-1:0]          t2_ff;
   logic [FRAC_BITS-1:0]          t3_ff;
   logic signed [AW-1:0]          a_val;
   logic signed [AW+FRAC_BITS:0]  p1;
   logic signed [AW+FRAC_BITS:0]  p1_sh;
   logic [BW-1:0]                 b_in;
   logic [BW-1:0]                 b_ff;
   logic [BW+FRAC_BITS-1:0]       p2;
   logic [CW+FRAC_BITS-1:0]       p3;
   logic [CW+FRAC_BITS-1:0]       p4;
   logic [CW-1:0]                 c1_in;
   logic [CW-1:0]                 c1_ff;
   logic [CW-1:0]                 c2_in;
   logic [CW-1:0]                 c2_ff;
   logic [FRAC_BITS:0]            fade_in;
   logic [FRAC_BITS:0]            fade_ff;

   always_comb begin
      a_val   = AW'(t0_ff) * AW'(6) - (AW'(15) << FRAC_BITS);
      p1      = a_val * $signed({1'b0, t0_ff});
      p1_sh   = p1 >>> FRAC_BITS;
      b_in    = p1_sh[BW-1:0] + (BW'(10) << FRAC_BITS);
      p2      = b_ff * t1_ff;
      c1_in   = p2[FRAC_BITS +: CW];
      p3      = c1_ff * t2_ff;
      c2_in   = p3[FRAC_BITS +: CW];
      p4      = c2_ff * t3_ff;
      fade_in = p4[FRAC_BITS +: FRAC_BITS+1];
   end

   always_ff @(posedge clock) begin
      t0_ff   <= t_in;
      t1_ff   <= t0_ff;
      t2_ff   <= t1_ff;
      t3_ff   <= t2_ff;
      b_ff    <= b_in;
      c1_ff   <= c1_in;
      c2_ff   <= c2_in;
      fade_ff <= fade_in;
   end

   assign fade = fade_ff;

endmodule

[rtl/core/pn2d_blend.sv]
// Corner gradients, bilinear blend by the fade weights and output scaling.
module pn2d_blend #(
   parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  pn2d_pkg::hash_type                hash,
   input  logic [FRAC_BITS-1:0]              fx,
   input  logic [FRAC_BITS-1:0]              fy,
   input  logic [FRAC_BITS:0]                u,
   input  logic [FRAC_BITS:0]                v,
   output logic signed [pn2d_pkg::OUT_W-1:0] noise_value
);
   import pn2d_pkg::*;

   localparam int DW    = FRAC_BITS + 2;
   localparam int HW    = FRAC_BITS + 3;
   localparam int EW    = FRAC_BITS + 4;
   localparam int MW    = 2 * FRAC_BITS + 6;
   localparam int SW    = HW + 1;
   localparam int WIDE  = HW + 9;
   localparam int SHIFT = FRAC_BITS + 1 - OUT_FRAC;
   localparam int SHR   = (SHIFT > 0) ? SHIFT : 0;
   localparam int SHL   = (SHIFT < 0) ? -SHIFT : 0;

   localparam logic signed [DW-1:0]   ONE_D = DW'(1) << FRAC_BITS;
   localparam logic signed [SW-1:0]   ONE_S = SW'(1) << FRAC_BITS;
   localparam logic signed [WIDE-1:0] LO    = WIDE'(OUT_MIN);
   localparam logic signed [WIDE-1:0] HI    = WIDE'(OUT_MAX);

   function automatic logic signed [HW-1:0] grad(
      input logic [2:0]           h,
      input logic signed [DW-1:0] dx,
      input logic signed [DW-1:0] dy
   );
      logic signed [HW-1:0] gu;
      logic signed [HW-1:0] gv;
      logic signed [HW-1:0] su;
      logic signed [HW-1:0] sv;
      gu = h[2] ? HW'(dy) : HW'(dx);
      gv = h[2] ? HW'(dx) : HW'(dy);
      su = h[0] ? -gu : gu;
      sv = h[1] ? -(gv <<< 1) : (gv <<< 1);
      return su + sv;
   endfunction

   logic [FRAC_BITS-1:0]   fx0_ff;
   logic [FRAC_BITS-1:0]   fy0_ff;
   logic [FRAC_BITS-1:0]   fx1_ff;
   logic [FRAC_BITS-1:0]   fy1_ff;
   logic signed [DW-1:0]   dx0;
   logic signed [DW-1:0]   dx1;
   logic signed [DW-1:0]   dy0;
   logic signed [DW-1:0]   dy1;
   logic signed [HW-1:0]   g00_in;
   logic signed [HW-1:0]   g10_in;
   logic signed [HW-1:0]   g01_in;
   logic signed [HW-1:0]   g11_in;
   logic signed [HW-1:0]   g00_ff;
   logic signed [HW-1:0]   g10_ff;
   logic signed [HW-1:0]   g01_ff;
   logic signed [HW-1:0]   g11_ff;
   logic signed [EW-1:0]   d0_in;
   logic signed [EW-1:0]   d1_in;
   logic signed [EW-1:0]   d0_ff;
   logic signed [EW-1:0]   d1_ff;
   logic signed [HW-1:0]   p0_ff;
   logic signed [HW-1:0]   p1_ff;
   logic signed [EW-1:0]   d0_dly_ff;
   logic signed [EW-1:0]   d1_dly_ff;
   logic signed [HW-1:0]   p0_dly_ff;
   logic signed [HW-1:0]   p1_dly_ff;
   logic signed [MW-1:0]   m0;
   logic signed [MW-1:0]   m1;
   logic signed [MW-1:0]   m0_sh;
   logic signed [MW-1:0]   m1_sh;
   logic signed [HW-1:0]   n0_in;
   logic signed [HW-1:0]   n1_in;
   logic signed [HW-1:0]   n0_ff;
   logic signed [HW-1:0]   n1_ff;
   logic [FRAC_BITS:0]     v5_ff;
   logic [FRAC_BITS:0]     v6_ff;
   logic signed [EW-1:0]   dn_in;
   logic signed [EW-1:0]   dn_ff;
   logic signed [HW-1:0]   n0b_ff;
   logic signed [MW-1:0]   m2;
   logic signed [MW-1:0]   m2_sh;
   logic signed [HW-1:0]   r_in;
   logic signed [HW-1:0]   r_ff;
   logic signed [SW-1:0]   s_val;
   logic signed [WIDE-1:0] o_wide;
   logic signed [WIDE-1:0] o_sat;

   // gradients at the four corners and their differences along x
   always_comb begin
      dx0    = $signed({2'b00, fx1_ff});
      dx1    = dx0 - ONE_D;
      dy0    = $signed({2'b00, fy1_ff});
      dy1    = dy0 - ONE_D;
      g00_in = grad(hash.aa[2:0], dx0, dy0);
      g10_in = grad(hash.ba[2:0], dx1, dy0);
      g01_in = grad(hash.ab[2:0], dx0, dy1);
      g11_in = grad(hash.bb[2:0], dx1, dy1);
      d0_in  = EW'(g10_ff) - EW'(g00_ff);
      d1_in  = EW'(g11_ff) - EW'(g01_ff);
   end

   // blend along x, then along y
   always_comb begin
      m0    = $signed({1'b0, u}) * d0_dly_ff;
      m1    = $signed({1'b0, u}) * d1_dly_ff;
      m0_sh = m0 >>> FRAC_BITS;
      m1_sh = m1 >>> FRAC_BITS;
      n0_in = p0_dly_ff + m0_sh[HW-1:0];
      n1_in = p1_dly_ff + m1_sh[HW-1:0];
      dn_in = EW'(n1_ff) - EW'(n0_ff);
      m2    = $signed({1'b0, v6_ff}) * dn_ff;
      m2_sh = m2 >>> FRAC_BITS;
      r_in  = n0b_ff + m2_sh[HW-1:0];
   end

   // (r + 1) / 2, rescaled to the output fraction width and clamped
   always_comb begin
      s_val  = SW'(r_ff) + ONE_S;
      o_wide = (WIDE'(s_val) >>> SHR) <<< SHL;
      if (o_wide < LO) begin
         o_sat = LO;
      end else if (o_wide > HI) begin
         o_sat = HI;
      end else begin
         o_sat = o_wide;
      end
      noise_value = o_sat[OUT_W-1:0];
   end

   always_ff @(posedge clock) begin
      fx0_ff    <= fx;
      fy0_ff    <= fy;
      fx1_ff    <= fx0_ff;
      fy1_ff    <= fy0_ff;
      g00_ff    <= g00_in;
      g10_ff    <= g10_in;
      g01_ff    <= g01_in;
      g11_ff    <= g11_in;
      d0_ff     <= d0_in;
      d1_ff     <= d1_in;
      p0_ff     <= g00_ff;
      p1_ff     <= g01_ff;
      d0_dly_ff <= d0_ff;
      d1_dly_ff <= d1_ff;
      p0_dly_ff <= p0_ff;
      p1_dly_ff <= p1_ff;
      n0_ff     <= n0_in;
      n1_ff     <= n1_in;
      v5_ff     <= v;
      dn_ff     <= dn_in;
      n0b_ff    <= n0_ff;
      v6_ff     <= v5_ff;
      r_ff      <= r_in;
   end

endmodule

[rtl/core/perlin_noise_2d.sv]
// Top level of the 2D gradient noise block: decode, pipeline control and result queue.
//
// One transaction per clock while req_tready is high: a load writes one permutation
// entry, an evaluate returns one noise sample through the pipeline into a 16-entry result
// queue, and from there through the output register. The table is held in three copies,
// each with two read ports, so the six table reads of a point (two cell reads, then four
// corner reads) each have a port of their own. The pipeline never stalls; req_tready drops
// only while 16 evaluate results are outstanding, which with rsp_tready held high does not
// happen. Table entries are undefined until loaded; there is no clearing pass after reset.
module perlin_noise_2d #(
   parameter int FRAC_BITS = pn2d_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // x_coord[23:0], y_coord[47:24], entry_index[55:48], entry_value[63:56]
   input  logic [pn2d_pkg::REQ_DATA_W-1:0] req_tdata,
   // mode[0]
   input  logic [pn2d_pkg::REQ_USER_W-1:0] req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // noise_value[18:0], zero pad[23:19]
   output logic [pn2d_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pn2d_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   logic                   req_accept;
   logic                   rsp_accept;
   mode_type               mode;
   logic [COORD_W-1:0]     x_coord;
   logic [COORD_W-1:0]     y_coord;
   logic [COORD_W-1:0]     x_int;
   logic [COORD_W-1:0]     y_int;
   idx_type                entry_index;
   val_type                entry_value;
   logic                   eval_en;
   wr_type                 wr;
   hash_type               hash;
   logic [FRAC_BITS:0]     fade_u;
   logic [FRAC_BITS:0]     fade_v;
   logic signed [OUT_W-1:0] noise_value;

   logic [PIPE_LAT-1:0]    vld_in;
   logic [PIPE_LAT-1:0]    vld_ff;
   logic [CNT_W-1:0]       inflight_in;
   logic [CNT_W-1:0]       inflight_ff;
   logic [CNT_W-1:0]       cnt_in;
   logic [CNT_W-1:0]       cnt_ff;
   logic [PTR_W-1:0]       wr_ptr_in;
   logic [PTR_W-1:0]       wr_ptr_ff;
   logic [PTR_W-1:0]       rd_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff;
   logic                   out_vld_in;
   logic                   out_vld_ff;
   logic                   push;
   logic                   pop;
   logic [OUT_W-1:0]       fifo_mem [FIFO_DEPTH];
   logic [OUT_W-1:0]       out_data_ff;

   assign mode        = mode_type'(req_tuser[0]);
   assign x_coord     = req_tdata[COORD_W-1:0];
   assign y_coord     = req_tdata[2*COORD_W-1:COORD_W];
   assign entry_index = req_tdata[2*COORD_W +: IDX_W];
   assign entry_value = req_tdata[2*COORD_W+IDX_W +: VAL_W];

   assign req_tready  = (inflight_ff < CNT_W'(FIFO_DEPTH));
   assign req_accept  = req_tvalid && req_tready;
   assign rsp_accept  = rsp_tvalid && rsp_tready;
   assign eval_en     = req_accept && (mode == MODE_EVAL);

   assign wr = '{en: req_accept && (mode == MODE_LOAD), addr: entry_index, data: entry_value};

   assign x_int = x_coord >> FRAC_BITS;
   assign y_int = y_coord >> FRAC_BITS;

   pn2d_hash u_hash (
      .clock (clock),
      .wr    (wr),
      .rd_en (eval_en),
      .cx    (x_int[IDX_W-1:0]),
      .cy    (y_int[IDX_W-1:0]),
      .hash  (hash)
   );

   pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_x (
      .clock (clock),
      .t_in  (x_coord[FRAC_BITS-1:0]),
      .fade  (fade_u)
   );

   pn2d_fade #(.FRAC_BITS(FRAC_BITS)) u_fade_y (
      .clock (clock),
      .t_in  (y_coord[FRAC_BITS-1:0]),
      .fade  (fade_v)
   );

   pn2d_blend #(.FRAC_BITS(FRAC_BITS)) u_blend (
      .clock       (clock),
      .hash        (hash),
      .fx          (x_coord[FRAC_BITS-1:0]),
      .fy          (y_coord[FRAC_BITS-1:0]),
      .u           (fade_u),
      .v           (fade_v),
      .noise_value (noise_value)
   );

   always_comb begin
      push        = vld_ff[PIPE_LAT-1];
      pop         = (cnt_ff != '0) && (!out_vld_ff || rsp_tready);
      vld_in      = {vld_ff[PIPE_LAT-2:0], eval_en};
      inflight_in = inflight_ff + CNT_W'(eval_en) - CNT_W'(rsp_accept);
      cnt_in      = cnt_ff + CNT_W'(push) - CNT_W'(pop);
      wr_ptr_in   = wr_ptr_ff + PTR_W'(push);
      rd_ptr_in   = rd_ptr_ff + PTR_W'(pop);
      out_vld_in  = pop || (out_vld_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         inflight_ff <= '0;
         cnt_ff      <= '0;
         wr_ptr_ff   <= '0;
         rd_ptr_ff   <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         vld_ff      <= vld_in;
         inflight_ff <= inflight_in;
         cnt_ff      <= cnt_in;
         wr_ptr_ff   <= wr_ptr_in;
         rd_ptr_ff   <= rd_ptr_in;
         out_vld_ff  <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_mem[wr_ptr_ff] <= noise_value;
      end
      if (pop) begin
         out_data_ff <= fifo_mem[rd_ptr_ff];
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = RSP_DATA_W'(out_data_ff);

endmodule

[rtl/core/perlin_noise_2d_checker.sv]
// Port-level checker of the 2D gradient noise block and its bind.
`include "perlin_noise_2d_assert.svh"

module perlin_noise_2d_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [pn2d_pkg::REQ_DATA_W-1:0] req_tdata,
   input logic [pn2d_pkg::REQ_USER_W-1:0] req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pn2d_pkg::RSP_DATA_W-1:0] rsp_tdata
);
   import pn2d_pkg::*;

   localparam int PEND_W = $clog2(FIFO_DEPTH + 2);

   logic              eval_seen;
   logic              rsp_seen;
   logic [PEND_W-1:0] pend_in;
   logic [PEND_W-1:0] pend_ff;

   // evaluates accepted but not yet answered; loads never count
   assign eval_seen = req_tvalid && req_tready && (mode_type'(req_tuser[0]) == MODE_EVAL)
                      && (req_tdata == req_tdata);
   assign rsp_seen  = rsp_tvalid && rsp_tready;
   assign pend_in   = pend_ff + PEND_W'(eval_seen) - PEND_W'(rsp_seen);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   `PN2D_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "result changed or dropped while stalled")
   `PN2D_ASSERT_IMPL(a_rsp_owed, clock, reset, rsp_tvalid, pend_ff != '0, "result without an outstanding evaluate")
   `PN2D_ASSERT_IMPL(a_rsp_pad, clock, reset, rsp_tvalid, rsp_tdata[RSP_DATA_W-1:OUT_W] == '0, "pad bits of result set")
   `PN2D_ASSERT_IMPL(a_rsp_range, clock, reset, rsp_tvalid, (rsp_tdata[OUT_W-1:0] <= 19'd131072) || (rsp_tdata[OUT_W-1:0] >= 19'h70000), "noise value out of range")

endmodule

bind perlin_noise_2d perlin_noise_2d_checker u_checker (.*);

[test/tb_top.sv]
// Self-checking testbench of perlin_noise_2d: table loads, noise evaluation and stream backpressure.
`timescale 1ns / 100ps

module tb_top;
   import pn2d_pkg::*;

   localparam int FRAC        = FRAC_BITS_DEF;
   localparam longint ONE     = longint'(1) << FRAC;
   localparam int CYCLE_LIMIT = 200000;
   localparam int RAND_ITEMS  = 1271;

   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [OUT_W-1:0]   noise_type;

   typedef struct {
      mode_type  mode;
      coord_type x;
      coord_type y;
      idx_type   idx;
      val_type   val;
      bit        known;
      noise_type noise;
   } stim_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [REQ_USER_W-1:0] req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   val_type   perm_copy [TABLE_SIZE];
   noise_type noise_expected [$];
   noise_type noise_want;
   int        errors = 0;
   int        cycle_count = 0;
   int        random_sent = 0;
   int        hold_left = 0;
   bit        hold_done = 1'b0;
   bit        gaps_on = 1'b1;

   // mode, x, y, index, value, known, expected noise
   stim_type directed_rows [0:22] = '{
      '{MODE_EVAL, 24'h000000, 24'h000000, 8'h00, 8'h00, 1'b1, 19'd32768},
      '{MODE_EVAL, 24'h010000, 24'hFF0000, 8'hFF, 8'hFF, 1'b1, 19'd32768},
      '{MODE_EVAL, 24'hFF0000, 24'h000000, 8'h00, 8'hFF, 1'b1, 19'd32768},
      '{MODE_EVAL, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h00FFFF, 24'h000000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h000000, 24'h00FFFF, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h008000, 24'h008000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_LOAD, 24'hFFFFFF, 24'hFFFFFF, 8'h01, 8'h01, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h02, 8'h02, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h03, 8'h03, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h04, 8'h04, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h05, 8'h05, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h06, 8'h06, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h07, 8'h07, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h004000, 24'h00C000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h00C000, 24'h024000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h002000, 24'h04E000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'h00FFFF, 24'h06FFFF, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'hFF, 8'hFF, 1'b0, 19'd0},
      '{MODE_LOAD, 24'h000000, 24'h000000, 8'h02, 8'hFD, 1'b0, 19'd0},
      '{MODE_EVAL, 24'hFF4000, 24'hFFC000, 8'h00, 8'h00, 1'b0, 19'd0},
      '{MODE_EVAL, 24'hFE8000, 24'h01FFFF, 8'h00, 8'h00, 1'b0, 19'd0}
   };

   perlin_noise_2d dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // quintic fade by Horner's rule, each product floored back to FRAC bits
   function automatic longint fade_q16(longint t);
      longint a, b, c;
      a = 6 * t - 15 * ONE;
      b = ((a * t) >>> FRAC) + 10 * ONE;
      c = (b * t) >>> FRAC;
      c = (c * t) >>> FRAC;
      return (c * t) >>> FRAC;
   endfunction

   function automatic longint blend_q16(longint w, longint p, longint q);
      return p + ((w * (q - p)) >>> FRAC);
   endfunction

   function automatic longint corner_gradient(val_type hash, longint dx, longint dy);
      longint u, v, su, sv;
      u  = hash[2] ? dy : dx;
      v  = hash[2] ? dx : dy;
      su = hash[0] ? -u : u;
      sv = hash[1] ? -2 * v : 2 * v;
      return su + sv;
   endfunction

   function automatic noise_type predict_noise(coord_type x, coord_type y);
      idx_type cx, cy, k;
      val_type hx0, hx1, aa, ab, ba, bb;
      longint  fx, fy, u, v, g00, g10, g01, g11, r, o;
      cx  = x[FRAC+IDX_W-1:FRAC];
      cy  = y[FRAC+IDX_W-1:FRAC];
      fx  = longint'(x[FRAC-1:0]);
      fy  = longint'(y[FRAC-1:0]);
      u   = fade_q16(fx);
      v   = fade_q16(fy);
      hx0 = perm_copy[cx];
      k   = cx + 1'b1;
      hx1 = perm_copy[k];
      k   = hx0 + cy;
      aa  = perm_copy[k];
      k   = k + 1'b1;
      ab  = perm_copy[k];
      k   = hx1 + cy;
      ba  = perm_copy[k];
      k   = k + 1'b1;
      bb  = perm_copy[k];
      g00 = corner_gradient(aa, fx, fy);
      g10 = corner_gradient(ba, fx - ONE, fy);
      g01 = corner_gradient(ab, fx, fy - ONE);
      g11 = corner_gradient(bb, fx - ONE, fy - ONE);
      r   = blend_q16(v, blend_q16(u, g00, g10), blend_q16(u, g01, g11));
      o   = (r + ONE) >>> (FRAC + 1 - OUT_FRAC);
      if (o < OUT_MIN) o = OUT_MIN;
      if (o > OUT_MAX) o = OUT_MAX;
      return o[OUT_W-1:0];
   endfunction

   function automatic coord_type rand_coord();
      logic [7:0]  ip;
      logic [15:0] fp;
      ip = 8'($urandom);
      fp = 16'($urandom);
      case ($urandom_range(0, 7))
         0: fp = '0;
         1: fp = '1;
         2: ip = '1;
         3: ip = '0;
         default: ;
      endcase
      return {ip, fp};
   endfunction

   task automatic send_item(input stim_type row);
      while (gaps_on && $urandom_range(0, 99) < 37) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= row.mode;
      req_tdata  <= {row.val, row.idx, row.y, row.x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (row.mode == MODE_LOAD)
         perm_copy[row.idx] = row.val;
      else
         noise_expected.push_back(row.known ? row.noise : predict_noise(row.x, row.y));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (noise_expected.size() == 0) begin
            $display("%0t: unexpected transaction, expected none, actual %0d", $time,
                     $signed(rsp_tdata[OUT_W-1:0]));
            errors++;
         end else begin
            noise_want = noise_expected.pop_front();
            if (rsp_tdata[OUT_W-1:0] !== noise_want) begin
               $display("%0t: noise_value expected %0d actual %0d", $time,
                        $signed(noise_want), $signed(rsp_tdata[OUT_W-1:0]));
               errors++;
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (!hold_done && random_sent >= 300) begin
         // long stall so the result queue fills and req_tready drops
         rsp_tready <= 1'b0;
         hold_left  <= 400;
         hold_done  <= 1'b1;
      end else if (random_sent >= 700 && random_sent < 1000) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) >= 37);
      end
   end

   initial begin
      stim_type row;
      val_type  shuffle [TABLE_SIZE];
      val_type  swap;
      int       j;
      foreach (perm_copy[i]) perm_copy[i] = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // every entry written before the first evaluation
      foreach (shuffle[i]) shuffle[i] = val_type'(i);
      for (int i = TABLE_SIZE - 1; i > 0; i--) begin
         j          = $urandom_range(0, i);
         swap       = shuffle[i];
         shuffle[i] = shuffle[j];
         shuffle[j] = swap;
      end
      for (int i = 0; i < TABLE_SIZE; i++) begin
         row = '{MODE_LOAD, rand_coord(), rand_coord(), idx_type'(i), shuffle[i], 1'b0, '0};
         send_item(row);
      end

      foreach (directed_rows[i]) send_item(directed_rows[i]);

      for (int n = 0; n < RAND_ITEMS; n++) begin
         random_sent = n;
         gaps_on     = !(n >= 700 && n < 1000);
         if (n == 1200) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (noise_expected.size() != 0);
         end
         row.mode  = ($urandom_range(0, 99) < 15) ? MODE_LOAD : MODE_EVAL;
         row.x     = rand_coord();
         row.y     = rand_coord();
         row.idx   = idx_type'($urandom);
         row.val   = val_type'($urandom);
         row.known = 1'b0;
         row.noise = '0;
         send_item(row);
      end
      random_sent = RAND_ITEMS;

      req_tvalid <= 1'b0;
      while (noise_expected.size() != 0) @(posedge clock);
      repeat (PIPE_LAT + 8) @(posedge clock);
      if (errors == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("simulation failed");
      $finish;
   end

endmodule
